/* hw/rtl/lcse_pkg.sv */
// lcse_pkg: shared types, constants and helpers for the led chain spi symbol encoder
// depends on nothing; every other file of the block refers to it by scoped names

package lcse_pkg;

	localparam int CMD_W    = 2;
	localparam int IDX_W    = 6;
	localparam int CHAN_W   = 8;
	localparam int PIXEL_W  = 3 * CHAN_W;
	localparam int BRIGHT_W = 7;
	localparam int BYTE_W   = 8;

	localparam int BYTES_PER_PIXEL = 12;
	localparam int LATCH_BYTES     = 26;
	localparam int BYTE_CNT_W      = 5;

	localparam int MUL_W   = CHAN_W + BRIGHT_W;
	localparam int QUO_W   = 9;
	localparam int STEP_W  = 4;

	localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd100;
	localparam logic [MUL_W-1:0]    DIV_INIT     = MUL_W'(100 << (QUO_W - 1));

	localparam logic [3:0] SYM_ONE  = 4'b1110;
	localparam logic [3:0] SYM_ZERO = 4'b1000;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_SEND  = 2'd1,
		CMD_LATCH = 2'd2
	} cmd_t;

	// load request from the control logic to the serializer
	typedef struct packed {
		logic pixel;
		logic latch;
	} ser_req_t;

	function automatic logic [3:0] symbol(input logic b);
		return b ? SYM_ONE : SYM_ZERO;
	endfunction

endpackage

/* hw/rtl/lcse_channels_if.sv */
// lcse_cmd_if and lcse_byte_if: valid/ready channels of the encoder
// depends on lcse_pkg for the field widths

interface lcse_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [lcse_pkg::CMD_W-1:0]  cmd;
	logic [lcse_pkg::IDX_W-1:0]  pixel_index;
	logic [lcse_pkg::CHAN_W-1:0] red_value;
	logic [lcse_pkg::CHAN_W-1:0] green_value;
	logic [lcse_pkg::CHAN_W-1:0] blue_value;

	modport source (output valid, cmd, pixel_index, red_value, green_value, blue_value,
		input ready);
	modport sink (input valid, cmd, pixel_index, red_value, green_value, blue_value,
		output ready);
endinterface

interface lcse_byte_if;
	logic                         valid;
	logic                         ready;
	logic [lcse_pkg::BYTE_W-1:0] spi_byte;
	logic                         last_of_run;

	modport source (output valid, spi_byte, last_of_run, input ready);
	modport sink (input valid, spi_byte, last_of_run, output ready);
endinterface

/* hw/rtl/lcse_pixel_store.sv */
// lcse_pixel_store: frame memory of rgb pixels with registered read
// per-entry valid flops make unwritten entries read as black; uses lcse_pkg

module lcse_pixel_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [lcse_pkg::PIXEL_W-1:0] wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [lcse_pkg::PIXEL_W-1:0] rd_data
);

	logic [lcse_pkg::PIXEL_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]             valid_q;
	logic [lcse_pkg::PIXEL_W-1:0] rd_data_q;
	logic                         rd_ok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_ok_q <= rd_en && valid_q[rd_addr];
		end
	end

	assign rd_data = rd_ok_q ? rd_data_q : '0;

endmodule

/* hw/rtl/lcse_scaler.sv */
// lcse_scaler: brightness scaling of three colour lanes, floor(c * b / 100), saturated
// bit-serial shift-add multiply then restoring division by a constant; uses lcse_pkg

module lcse_scaler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lcse_pkg::PIXEL_W-1:0]  pixel,
	input  logic [lcse_pkg::BRIGHT_W-1:0] brightness,
	output logic                           done,
	output logic [lcse_pkg::PIXEL_W-1:0]  scaled
);

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_MUL,
		SC_DIV
	} sc_state_t;

	sc_state_t                         state_q;
	logic [lcse_pkg::STEP_W-1:0]       step_q;
	logic                              done_q;
	logic [lcse_pkg::CHAN_W-1:0]       chan_q [3];
	logic [lcse_pkg::MUL_W-1:0]        acc_q  [3];
	logic [lcse_pkg::QUO_W-1:0]        quo_q  [3];
	logic [lcse_pkg::MUL_W-1:0]        div_q;

	// lane 0 green, lane 1 red, lane 2 blue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (start) begin
						state_q <= SC_MUL;
						step_q  <= lcse_pkg::STEP_W'(lcse_pkg::CHAN_W - 1);
					end
				end
				SC_MUL: begin
					if (step_q == '0) begin
						state_q <= SC_DIV;
						step_q  <= lcse_pkg::STEP_W'(lcse_pkg::QUO_W - 1);
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				SC_DIV: begin
					if (step_q == '0) begin
						state_q <= SC_IDLE;
						done_q  <= 1'b1;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				if (start) begin
					chan_q[0] <= pixel[lcse_pkg::CHAN_W +: lcse_pkg::CHAN_W];
					chan_q[1] <= pixel[2*lcse_pkg::CHAN_W +: lcse_pkg::CHAN_W];
					chan_q[2] <= pixel[0 +: lcse_pkg::CHAN_W];
					for (int i = 0; i < 3; i++) begin
						acc_q[i] <= '0;
					end
				end
			end
			SC_MUL: begin
				for (int i = 0; i < 3; i++) begin
					acc_q[i]  <= {acc_q[i][lcse_pkg::MUL_W-2:0], 1'b0}
						+ (chan_q[i][lcse_pkg::CHAN_W-1] ?
						lcse_pkg::MUL_W'(brightness) : '0);
					chan_q[i] <= {chan_q[i][lcse_pkg::CHAN_W-2:0], 1'b0};
					quo_q[i]  <= '0;
				end
				div_q <= lcse_pkg::DIV_INIT;
			end
			SC_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if (acc_q[i] >= div_q) begin
						acc_q[i] <= acc_q[i] - div_q;
						quo_q[i] <= {quo_q[i][lcse_pkg::QUO_W-2:0], 1'b1};
					end else begin
						quo_q[i] <= {quo_q[i][lcse_pkg::QUO_W-2:0], 1'b0};
					end
				end
				div_q <= {1'b0, div_q[lcse_pkg::MUL_W-1:1]};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			scaled[(2-i)*lcse_pkg::CHAN_W +: lcse_pkg::CHAN_W] =
				quo_q[i][lcse_pkg::QUO_W-1] ? '1 : quo_q[i][lcse_pkg::CHAN_W-1:0];
		end
	end

	assign done = done_q;

endmodule

/* hw/rtl/lcse_serializer.sv */
// lcse_serializer: turns a scaled g,r,b word into twelve symbol bytes, or a zero reset run
// two colour bits leave the shift register per byte; drives lcse_byte_if; uses lcse_pkg

module lcse_serializer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lcse_pkg::ser_req_t            req,
	input  logic [lcse_pkg::PIXEL_W-1:0] grb,
	output logic                          busy,
	lcse_byte_if.source                   link
);

	logic [lcse_pkg::BYTE_CNT_W-1:0] cnt_q;
	logic                            latch_q;
	logic [lcse_pkg::PIXEL_W-1:0]    shift_q;
	logic                            valid_q;
	logic [lcse_pkg::BYTE_W-1:0]     byte_q;
	logic                            last_q;
	logic                            advance;

	assign advance = (cnt_q != '0) && (!valid_q || link.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			latch_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (valid_q && link.ready) begin
				valid_q <= 1'b0;
			end
			if (req.pixel) begin
				cnt_q   <= lcse_pkg::BYTE_CNT_W'(lcse_pkg::BYTES_PER_PIXEL);
				latch_q <= 1'b0;
			end else if (req.latch) begin
				cnt_q   <= lcse_pkg::BYTE_CNT_W'(lcse_pkg::LATCH_BYTES);
				latch_q <= 1'b1;
			end else if (advance) begin
				cnt_q   <= cnt_q - 1'b1;
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.pixel) begin
			shift_q <= grb;
		end else if (advance) begin
			shift_q <= {shift_q[lcse_pkg::PIXEL_W-3:0], 2'b00};
			byte_q  <= latch_q ? '0 : {lcse_pkg::symbol(shift_q[lcse_pkg::PIXEL_W-1]),
				lcse_pkg::symbol(shift_q[lcse_pkg::PIXEL_W-2])};
			last_q  <= (cnt_q == lcse_pkg::BYTE_CNT_W'(1));
		end
	end

	assign busy             = (cnt_q != '0);
	assign link.valid       = valid_q;
	assign link.spi_byte    = byte_q;
	assign link.last_of_run = last_q;

endmodule

/* hw/rtl/led_chain_spi_symbol_encoder.sv */
// led_chain_spi_symbol_encoder: top level of the led chain spi symbol encoder
// depends on lcse_pkg, lcse_channels_if, lcse_pixel_store, lcse_scaler, lcse_serializer
//
// host carries command items: a pixel write stores a colour by index and gives no
// output, a send emits the twelve symbol bytes of the next chain pixel (green, red,
// blue, msb first, serpentine order), a latch emits twenty-six zero bytes and rewinds
// the chain. link carries the bytes; last_of_run marks the final byte of a command.
// cfg_we/cfg_wdata write the brightness percent; write it only while the block is idle.
// A send does a store read, then runs the bit-serial scaler (8 multiply steps, 9
// divide steps), then loads the serializer, then emits one byte per cycle while link
// is ready. A latch loads the serializer with the zero run. When link stalls, the
// byte in the output register holds and the serializer waits; host ready stays low
// until the last byte of the run is loaded.
// Reset clears the chain position, sets brightness to 100 and marks every stored
// pixel black through per-entry valid flops; no clearing pass is needed.

module led_chain_spi_symbol_encoder #(
	parameter int NUM_LEDS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lcse_pkg::BRIGHT_W-1:0] cfg_wdata,
	lcse_cmd_if.sink                       host,
	lcse_byte_if.source                    link
);

	localparam int POS_W       = $clog2(NUM_LEDS);
	localparam int POS_XW      = (POS_W < 4) ? 4 : POS_W;
	localparam int STORE_DEPTH = (NUM_LEDS < (1 << lcse_pkg::IDX_W)) ?
		NUM_LEDS : (1 << lcse_pkg::IDX_W);
	localparam int MEM_AW      = $clog2(STORE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCALE
	} state_t;

	state_t                          state_q;
	logic [POS_W-1:0]                pos_q;
	logic [lcse_pkg::BRIGHT_W-1:0]  bright_q;
	logic                            accept;
	logic                            wr_en;
	logic                            rd_en;
	logic [POS_XW-1:0]               pos_x;
	logic [POS_XW-1:0]               mapped;
	logic                            mapped_ok;
	logic [lcse_pkg::PIXEL_W-1:0]   rd_pixel;
	logic                            sc_start;
	logic                            sc_done;
	logic [lcse_pkg::PIXEL_W-1:0]   sc_grb;
	logic                            ser_busy;
	lcse_pkg::ser_req_t              ser_req;

	assign host.ready = (state_q == ST_IDLE) && !ser_busy;
	assign accept     = host.valid && host.ready;

	// odd rows of eight run backwards
	assign pos_x     = POS_XW'(pos_q);
	assign mapped    = pos_x[3] ? (pos_x ^ POS_XW'(7)) : pos_x;
	assign mapped_ok = ({1'b0, mapped} < (POS_XW + 1)'(STORE_DEPTH));

	assign wr_en = accept && (lcse_pkg::cmd_t'(host.cmd) == lcse_pkg::CMD_WRITE)
		&& ({1'b0, host.pixel_index} < (lcse_pkg::IDX_W + 1)'(STORE_DEPTH));
	assign rd_en = accept && (lcse_pkg::cmd_t'(host.cmd) == lcse_pkg::CMD_SEND) && mapped_ok;

	assign sc_start      = (state_q == ST_READ);
	assign ser_req.pixel = sc_done;
	assign ser_req.latch = accept && (lcse_pkg::cmd_t'(host.cmd) == lcse_pkg::CMD_LATCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= lcse_pkg::BRIGHT_RESET;
		end else if (cfg_we) begin
			bright_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (lcse_pkg::cmd_t'(host.cmd))
							lcse_pkg::CMD_SEND: begin
								state_q <= ST_READ;
								pos_q   <= (pos_q == POS_W'(NUM_LEDS - 1)) ?
									'0 : pos_q + 1'b1;
							end
							lcse_pkg::CMD_LATCH: begin
								pos_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (sc_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	lcse_pixel_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (MEM_AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (host.pixel_index[MEM_AW-1:0]),
		.wr_data ({host.red_value, host.green_value, host.blue_value}),
		.rd_en   (rd_en),
		.rd_addr (mapped[MEM_AW-1:0]),
		.rd_data (rd_pixel)
	);

	lcse_scaler u_scaler (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (sc_start),
		.pixel      (rd_pixel),
		.brightness (bright_q),
		.done       (sc_done),
		.scaled     (sc_grb)
	);

	lcse_serializer u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ser_req),
		.grb    (sc_grb),
		.busy   (ser_busy),
		.link   (link)
	);

`ifndef SYNTHESIS
	a_send_blocks_next: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (lcse_pkg::cmd_t'(host.cmd) == lcse_pkg::CMD_SEND)) |=> !host.ready)
		else $error("host ready right after a send item");

	a_done_in_scale: assert property (@(posedge clk) disable iff (!arst_n)
		sc_done |-> (state_q == ST_SCALE))
		else $error("scaler finished outside of a send");

	a_byte_symbols: assert property (@(posedge clk) disable iff (!arst_n)
		link.valid |-> ((link.spi_byte == '0)
		|| (link.spi_byte[7:4] == lcse_pkg::SYM_ONE)
		|| (link.spi_byte[7:4] == lcse_pkg::SYM_ZERO)))
		else $error("output byte is neither a symbol pair nor a reset byte");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(pos_q) < NUM_LEDS))
		else $error("chain position past the last led");
`endif

endmodule
